// ===== hdl/npcs_pkg.sv =====
// Shared types and constants for the nearest palette color search pipeline.
package npcs_pkg;

   localparam int PALETTE_DEPTH     = 64;
   localparam int ENTRIES_PER_STAGE = 4;
   localparam int STAGE_COUNT       = PALETTE_DEPTH / ENTRIES_PER_STAGE;
   localparam int INDEX_WIDTH       = 6;
   localparam int ENTRY_SEL_WIDTH   = $clog2(ENTRIES_PER_STAGE);
   localparam int STAGE_SEL_WIDTH   = INDEX_WIDTH - ENTRY_SEL_WIDTH;
   localparam int COUNT_WIDTH       = INDEX_WIDTH + 1;
   localparam int COLOR_WIDTH       = 32;
   localparam int BYTE_WIDTH        = 8;
   localparam int BYTE_COUNT        = COLOR_WIDTH / BYTE_WIDTH;
   localparam int DIST_WIDTH        = 10;
   localparam int BEST_DIST_WIDTH   = 16;
   localparam int REQ_DATA_WIDTH    = 72;
   localparam int RSP_DATA_WIDTH    = 56;

   localparam logic [COLOR_WIDTH-1:0]     EMPTY_COLOR    = 32'h663399ff;
   localparam logic [BEST_DIST_WIDTH-1:0] EMPTY_DISTANCE = 16'hffff;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   typedef struct packed {
      logic                       kind;
      logic [INDEX_WIDTH-1:0]     entry_index;
      logic [COLOR_WIDTH-1:0]     entry_color;
      logic [COLOR_WIDTH-1:0]     pixel;
      logic                       frame_end;
      logic [COLOR_WIDTH-1:0]     best_color;
      logic [INDEX_WIDTH-1:0]     best_index;
      logic [BEST_DIST_WIDTH-1:0] best_dist;
   } item_type;

endpackage

// ===== hdl/npcs_dist.sv =====
// Sum of absolute byte differences between two 32-bit colors.
module npcs_dist (
   input  logic [npcs_pkg::COLOR_WIDTH-1:0] color_a,
   input  logic [npcs_pkg::COLOR_WIDTH-1:0] color_b,
   output logic [npcs_pkg::DIST_WIDTH-1:0]  distance
);

   logic [npcs_pkg::BYTE_WIDTH-1:0] diff [npcs_pkg::BYTE_COUNT];

   always_comb begin
      for (int b = 0; b < npcs_pkg::BYTE_COUNT; b++) begin
         if (color_a[b*npcs_pkg::BYTE_WIDTH +: npcs_pkg::BYTE_WIDTH] >
             color_b[b*npcs_pkg::BYTE_WIDTH +: npcs_pkg::BYTE_WIDTH]) begin
            diff[b] = color_a[b*npcs_pkg::BYTE_WIDTH +: npcs_pkg::BYTE_WIDTH] -
                      color_b[b*npcs_pkg::BYTE_WIDTH +: npcs_pkg::BYTE_WIDTH];
         end else begin
            diff[b] = color_b[b*npcs_pkg::BYTE_WIDTH +: npcs_pkg::BYTE_WIDTH] -
                      color_a[b*npcs_pkg::BYTE_WIDTH +: npcs_pkg::BYTE_WIDTH];
         end
      end
   end

   // Two levels of adders; every sum stays below 1021.
   assign distance = (npcs_pkg::DIST_WIDTH'(diff[0]) + npcs_pkg::DIST_WIDTH'(diff[1])) +
                     (npcs_pkg::DIST_WIDTH'(diff[2]) + npcs_pkg::DIST_WIDTH'(diff[3]));

endmodule

// ===== hdl/npcs_stage.sv =====
// One search stage: holds a group of palette entries and refines the running best match.
module npcs_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [npcs_pkg::STAGE_SEL_WIDTH-1:0] group_sel,
   input  logic [npcs_pkg::COUNT_WIDTH-1:0]     count,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  npcs_pkg::item_type                   in_item,
   output logic                                out_valid,
   input  logic                                out_ready,
   output npcs_pkg::item_type                   out_item
);

   logic [npcs_pkg::COLOR_WIDTH-1:0] entry_ff [npcs_pkg::ENTRIES_PER_STAGE];
   logic [npcs_pkg::DIST_WIDTH-1:0]  entry_distance [npcs_pkg::ENTRIES_PER_STAGE];
   logic [npcs_pkg::INDEX_WIDTH-1:0] slot_index [npcs_pkg::ENTRIES_PER_STAGE];
   logic                             valid_ff;
   logic                             valid_in;
   npcs_pkg::item_type               item_ff;
   npcs_pkg::item_type               item_in;
   logic                             load;
   logic                             write_hit;

   assign in_ready  = !valid_ff || out_ready;
   assign load      = in_valid && in_ready;
   assign write_hit = (in_item.kind == npcs_pkg::KIND_WRITE) &&
      (in_item.entry_index[npcs_pkg::INDEX_WIDTH-1:npcs_pkg::ENTRY_SEL_WIDTH] == group_sel);

   for (genvar e = 0; e < npcs_pkg::ENTRIES_PER_STAGE; e++) begin : g_entry
      assign slot_index[e] = {group_sel, npcs_pkg::ENTRY_SEL_WIDTH'(e)};
      npcs_dist u_dist (
         .color_a  (in_item.pixel),
         .color_b  (entry_ff[e]),
         .distance (entry_distance[e])
      );
   end

   // Entries are visited in index order with a strict compare, so ties keep the lower index.
   always_comb begin
      item_in = in_item;
      for (int e = 0; e < npcs_pkg::ENTRIES_PER_STAGE; e++) begin
         if (in_item.kind == npcs_pkg::KIND_PIXEL &&
             {1'b0, slot_index[e]} < count &&
             npcs_pkg::BEST_DIST_WIDTH'(entry_distance[e]) < item_in.best_dist) begin
            item_in.best_dist  = npcs_pkg::BEST_DIST_WIDTH'(entry_distance[e]);
            item_in.best_color = entry_ff[e];
            item_in.best_index = slot_index[e];
         end
      end
   end

   assign valid_in = load ? 1'b1 : (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && write_hit) begin
         entry_ff[in_item.entry_index[npcs_pkg::ENTRY_SEL_WIDTH-1:0]] <= in_item.entry_color;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

`ifndef NO_ASSERTIONS
   a_dist_never_grows: assert property (@(posedge clock) disable iff (reset)
      load |=> item_ff.best_dist <= $past(in_item.best_dist))
      else $error("best distance grew inside a search stage");

   a_write_keeps_best: assert property (@(posedge clock) disable iff (reset)
      (load && in_item.kind == npcs_pkg::KIND_WRITE) |=>
      item_ff.best_dist == $past(in_item.best_dist) &&
      item_ff.best_index == $past(in_item.best_index))
      else $error("palette write changed the running best match");

   a_found_dist_range: assert property (@(posedge clock) disable iff (reset)
      (load && in_item.kind == npcs_pkg::KIND_PIXEL &&
       in_item.best_dist == npcs_pkg::EMPTY_DISTANCE &&
       {1'b0, slot_index[0]} < count) |=>
      item_ff.best_dist <= npcs_pkg::BEST_DIST_WIDTH'(1020))
      else $error("searched entry did not produce a byte-sum distance");
`endif

endmodule

// ===== hdl/nearest_palette_color_sad.sv =====
// Top level of the nearest palette color search (sum of absolute byte differences).
//
//   Channel | Direction | Fields (tdata lowest bit first; tuser; tlast)
//   --------+-----------+------------------------------------------------------------
//   req     | in        | tdata: entry_index, entry_color, pixel; tuser: kind;
//           |           | tlast: frame_end
//   rsp     | out       | tdata: mapped_color, best_index, best_distance;
//           |           | tlast: frame_end_out
//   csr     | in        | wdata: palette_size, written when csr_we is high
//
// One transfer is accepted per cycle while the chain is not stalled; a pixel's result passes through
// the chain of sixteen search stages of four entries each and then the output register.
// Palette writes travel down the same chain, so each stage updates its entries in item order.
// Reset clears the stage and output valid bits and palette_size; the palette holds no reset value.
// Each stage holds its item while the stage after it is full and stalled, so nothing is lost.
module nearest_palette_color_sad (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [5:0] entry_index, [37:6] entry_color, [69:38] pixel, [71:70] unused
   input  logic [npcs_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // [0] kind
   input  logic                                 req_tuser,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] mapped_color, [37:32] best_index, [53:38] best_distance, [55:54] zero
   output logic [npcs_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [npcs_pkg::COUNT_WIDTH-1:0]     csr_wdata
);

   localparam int G = npcs_pkg::STAGE_COUNT;

   logic [npcs_pkg::COUNT_WIDTH-1:0] palette_size_ff;
   logic [npcs_pkg::COUNT_WIDTH-1:0] search_count;

   logic                link_valid [G+1];
   logic                link_ready [G+1];
   npcs_pkg::item_type  link_item  [G+1];

   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [npcs_pkg::COLOR_WIDTH-1:0]    rsp_color_ff;
   logic [npcs_pkg::INDEX_WIDTH-1:0]    rsp_index_ff;
   logic [npcs_pkg::BEST_DIST_WIDTH-1:0] rsp_dist_ff;
   logic                               rsp_last_ff;
   logic                               rsp_load;

   // The user must write the palette size register only while the pipeline is empty; the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         palette_size_ff <= '0;
      end else if (csr_we) begin
         palette_size_ff <= csr_wdata;
      end
   end

   // Sizes larger than the table search the whole table.
   assign search_count = (palette_size_ff > npcs_pkg::COUNT_WIDTH'(npcs_pkg::PALETTE_DEPTH)) ?
                         npcs_pkg::COUNT_WIDTH'(npcs_pkg::PALETTE_DEPTH) : palette_size_ff;

   // A new item starts with the empty-palette answer; stages replace it with real matches.
   always_comb begin
      link_item[0].kind        = req_tuser;
      link_item[0].entry_index = req_tdata[5:0];
      link_item[0].entry_color = req_tdata[37:6];
      link_item[0].pixel       = req_tdata[69:38];
      link_item[0].frame_end   = req_tlast;
      link_item[0].best_color  = npcs_pkg::EMPTY_COLOR;
      link_item[0].best_index  = '0;
      link_item[0].best_dist   = npcs_pkg::EMPTY_DISTANCE;
   end

   assign link_valid[0] = req_tvalid;
   assign req_tready    = link_ready[0];

   for (genvar g = 0; g < G; g++) begin : g_stage
      npcs_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .group_sel (npcs_pkg::STAGE_SEL_WIDTH'(g)),
         .count     (search_count),
         .in_valid  (link_valid[g]),
         .in_ready  (link_ready[g]),
         .in_item   (link_item[g]),
         .out_valid (link_valid[g+1]),
         .out_ready (link_ready[g+1]),
         .out_item  (link_item[g+1])
      );
   end

   // Output register: write items leave the chain here without producing a transfer.
   assign link_ready[G] = !rsp_valid_ff || rsp_tready;
   assign rsp_load      = link_valid[G] && link_ready[G] &&
                          (link_item[G].kind == npcs_pkg::KIND_PIXEL);
   assign rsp_valid_in  = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_color_ff <= link_item[G].best_color;
         rsp_index_ff <= link_item[G].best_index;
         rsp_dist_ff  <= link_item[G].best_dist;
         rsp_last_ff  <= link_item[G].frame_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_dist_ff, rsp_index_ff, rsp_color_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
